>>> sv/bankers_safety_and_request_check_defines.svh
// Assertion macros used by the top module to check its own behavior.
`ifndef BANKERS_SAFETY_AND_REQUEST_CHECK_DEFINES_SVH
`define BANKERS_SAFETY_AND_REQUEST_CHECK_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSRC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsrc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BSRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsrc assertion failed");

`endif

>>> sv/bsrc_pkg.sv
`default_nettype none
package bsrc_pkg;
  localparam int NPROC = 8;
  localparam int NRES = 4;
  localparam int COUNT_BITS = 8;
  localparam int CW = COUNT_BITS;
  localparam int PW = (NPROC > 1) ? $clog2(NPROC) : 1;
  localparam int AW = CW + PW + 1;

  localparam logic [2:0] CMD_MAX = 3'd0;
  localparam logic [2:0] CMD_ALLOC = 3'd1;
  localparam logic [2:0] CMD_TOTAL = 3'd2;
  localparam logic [2:0] CMD_SAFETY = 3'd3;
  localparam logic [2:0] CMD_REQUEST = 3'd4;

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_SAFE = 3'd1;
  localparam logic [2:0] ST_UNSAFE = 3'd2;
  localparam logic [2:0] ST_NEED = 3'd3;
  localparam logic [2:0] ST_AVAIL = 3'd4;

  typedef struct packed {
    logic          latch_in;
    logic          load_row;
    logic          avail_init;
    logic          avail_sub;
    logic          grant;
    logic          rollback;
    logic          scan_clear;
    logic          scan_take;
    logic          row_from_pid;
    logic [PW-1:0] idx;
    logic [PW-1:0] round;
    logic [PW-1:0] k;
    logic          out_load;
    logic          out_from_order;
    logic [2:0]    out_status;
    logic          out_last;
  } dp_ctrl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       pid_ok;
    logic [2:0] req_code;
    logic       fits;
    logic       out_free;
  } dp_stat_t;
endpackage
`default_nettype wire

>>> sv/bankers_safety_and_request_check.sv
// Banker's algorithm unit: items load claim rows, allocation rows or totals, run a
// safety check, or present a request that is granted only when the result stays safe.
// One item is taken at a time. A load is latched, written in the decode state, and its
// result then goes to the output register. A check first subtracts every allocation row
// from the totals (one row per cycle), then scans one process per cycle for up to 8
// rounds of up to 8 rows; a safe outcome then sends 8 items at one per cycle unless the
// output stalls. The next item is taken once the last result is in the output register.
`default_nettype none
`include "bankers_safety_and_request_check_defines.svh"
module bankers_safety_and_request_check import bsrc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_cmd,
  input  wire logic [2:0] in_process_id,
  input  wire logic [7:0] in_amount_r0,
  input  wire logic [7:0] in_amount_r1,
  input  wire logic [7:0] in_amount_r2,
  input  wire logic [7:0] in_amount_r3,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_status,
  output logic [2:0]      out_seq_process,
  output logic            out_last
);
  dp_ctrl_t ctrl;
  dp_stat_t stat;

  bsrc_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  bsrc_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_cmd          (in_cmd),
    .in_process_id   (in_process_id),
    .in_amount_r0    (in_amount_r0),
    .in_amount_r1    (in_amount_r1),
    .in_amount_r2    (in_amount_r2),
    .in_amount_r3    (in_amount_r3),
    .out_ready       (out_ready),
    .ctrl            (ctrl),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_seq_process (out_seq_process),
    .out_last        (out_last)
  );

  `BSRC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `BSRC_ASSERT_SAME(a_single_is_last, out_valid && out_status != ST_SAFE, out_last)
  `BSRC_ASSERT_SAME(a_single_no_seq, out_valid && out_status != ST_SAFE, out_seq_process == 3'd0)
endmodule
`default_nettype wire

>>> sv/bsrc_datapath.sv
`default_nettype none
module bsrc_datapath import bsrc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [2:0]  in_process_id,
  input  wire logic [7:0]  in_amount_r0,
  input  wire logic [7:0]  in_amount_r1,
  input  wire logic [7:0]  in_amount_r2,
  input  wire logic [7:0]  in_amount_r3,
  input  wire logic        out_ready,
  input  wire dp_ctrl_t    ctrl,
  output dp_stat_t         stat,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [2:0]       out_seq_process,
  output logic             out_last
);
  logic [CW-1:0] claim_r [NPROC][NRES];
  logic [CW-1:0] alloc_r [NPROC][NRES];
  logic [CW-1:0] total_r [NRES];
  logic [AW-1:0] avail_r [NRES];
  logic [NPROC-1:0] done_r;
  logic [PW-1:0] order_r [NPROC];
  logic [2:0] cmd_r;
  logic [2:0] pid_r;
  logic [CW-1:0] amt_r [NRES];
  logic out_valid_r;
  logic [2:0] out_status_r;
  logic [2:0] out_seq_r;
  logic out_last_r;

  logic [CW-1:0] amt_all [4];
  logic [PW-1:0] rsel;
  logic [PW-1:0] prow;
  logic [CW-1:0] need [NRES];
  logic fits;
  logic [2:0] req_code;
  logic pid_ok;

  assign amt_all[0] = in_amount_r0[CW-1:0];
  assign amt_all[1] = in_amount_r1[CW-1:0];
  assign amt_all[2] = in_amount_r2[CW-1:0];
  assign amt_all[3] = in_amount_r3[CW-1:0];

  assign pid_ok = (int'(pid_r) < NPROC);
  assign prow = PW'(pid_r);
  assign rsel = ctrl.row_from_pid ? prow : ctrl.idx;

  always_comb begin
    fits = !done_r[ctrl.idx];
    req_code = ST_LOAD;
    for (int r = 0; r < NRES; r++) begin
      need[r] = (claim_r[rsel][r] > alloc_r[rsel][r]) ?
                (claim_r[rsel][r] - alloc_r[rsel][r]) : '0;
      if ($signed(avail_r[r]) < $signed({{(AW-CW){1'b0}}, need[r]})) begin
        fits = 1'b0;
      end
    end
    for (int r = NRES - 1; r >= 0; r--) begin
      if (amt_r[r] > need[r]) begin
        req_code = ST_NEED;
      end else if ($signed({{(AW-CW){1'b0}}, amt_r[r]}) > $signed(avail_r[r])) begin
        req_code = ST_AVAIL;
      end
    end
  end

  assign stat.cmd = cmd_r;
  assign stat.pid_ok = pid_ok;
  assign stat.req_code = req_code;
  assign stat.fits = fits;
  assign stat.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NPROC; p++) begin
        for (int r = 0; r < NRES; r++) begin
          claim_r[p][r] <= '0;
          alloc_r[p][r] <= '0;
        end
      end
      for (int r = 0; r < NRES; r++) begin
        total_r[r] <= '0;
      end
      done_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.load_row) begin
        if (cmd_r == CMD_TOTAL) begin
          for (int r = 0; r < NRES; r++) total_r[r] <= amt_r[r];
        end else if (pid_ok && cmd_r == CMD_MAX) begin
          for (int r = 0; r < NRES; r++) claim_r[prow][r] <= amt_r[r];
        end else if (pid_ok && cmd_r == CMD_ALLOC) begin
          for (int r = 0; r < NRES; r++) alloc_r[prow][r] <= amt_r[r];
        end
      end
      if (ctrl.grant) begin
        for (int r = 0; r < NRES; r++) alloc_r[prow][r] <= alloc_r[prow][r] + amt_r[r];
      end
      if (ctrl.rollback) begin
        for (int r = 0; r < NRES; r++) alloc_r[prow][r] <= alloc_r[prow][r] - amt_r[r];
      end
      if (ctrl.scan_clear) begin
        done_r <= '0;
      end else if (ctrl.scan_take) begin
        done_r[ctrl.idx] <= 1'b1;
      end
      if (ctrl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.latch_in) begin
      cmd_r <= in_cmd;
      pid_r <= in_process_id;
      for (int r = 0; r < NRES; r++) amt_r[r] <= amt_all[r];
    end
    for (int r = 0; r < NRES; r++) begin
      if (ctrl.avail_init) begin
        avail_r[r] <= {{(AW-CW){1'b0}}, total_r[r]};
      end else if (ctrl.avail_sub) begin
        avail_r[r] <= avail_r[r] - {{(AW-CW){1'b0}}, alloc_r[rsel][r]};
      end else if (ctrl.grant) begin
        avail_r[r] <= avail_r[r] - {{(AW-CW){1'b0}}, amt_r[r]};
      end else if (ctrl.scan_take) begin
        avail_r[r] <= avail_r[r] + {{(AW-CW){1'b0}}, alloc_r[rsel][r]};
      end
    end
    if (ctrl.scan_take) begin
      order_r[ctrl.round] <= ctrl.idx;
    end
    if (ctrl.out_load) begin
      out_status_r <= ctrl.out_status;
      out_seq_r <= ctrl.out_from_order ? 3'(order_r[ctrl.k]) : 3'd0;
      out_last_r <= ctrl.out_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_seq_process = out_seq_r;
  assign out_last = out_last_r;
endmodule
`default_nettype wire

>>> sv/bsrc_controller.sv
`default_nettype none
module bsrc_controller import bsrc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output dp_ctrl_t      ctrl
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_AVINIT = 4'd2;
  localparam logic [3:0] S_AVSUB = 4'd3;
  localparam logic [3:0] S_REQCHK = 4'd4;
  localparam logic [3:0] S_SCANINIT = 4'd5;
  localparam logic [3:0] S_SCAN = 4'd6;
  localparam logic [3:0] S_ROLLBACK = 4'd7;
  localparam logic [3:0] S_RESP = 4'd8;
  localparam logic [3:0] S_EMIT = 4'd9;
  localparam logic [PW-1:0] LAST_IDX = PW'(NPROC - 1);

  logic [3:0] state_r, state_nxt;
  logic [PW-1:0] idx_r, idx_nxt;
  logic [PW-1:0] round_r, round_nxt;
  logic [PW-1:0] k_r, k_nxt;
  logic is_req_r, is_req_nxt;
  logic [2:0] code_r, code_nxt;

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    round_nxt = round_r;
    k_nxt = k_r;
    is_req_nxt = is_req_r;
    code_nxt = code_r;
    ctrl = '0;
    ctrl.idx = idx_r;
    ctrl.round = round_r;
    ctrl.k = k_r;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.latch_in = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        is_req_nxt = (stat.cmd == CMD_REQUEST);
        if (stat.cmd == CMD_MAX || stat.cmd == CMD_ALLOC || stat.cmd == CMD_TOTAL) begin
          ctrl.load_row = 1'b1;
          code_nxt = ST_LOAD;
          state_nxt = S_RESP;
        end else if (stat.cmd == CMD_SAFETY) begin
          state_nxt = S_AVINIT;
        end else if (stat.cmd == CMD_REQUEST) begin
          if (stat.pid_ok) begin
            state_nxt = S_AVINIT;
          end else begin
            code_nxt = ST_NEED;
            state_nxt = S_RESP;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_AVINIT: begin
        ctrl.avail_init = 1'b1;
        idx_nxt = '0;
        state_nxt = S_AVSUB;
      end
      S_AVSUB: begin
        ctrl.avail_sub = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = is_req_r ? S_REQCHK : S_SCANINIT;
        end
      end
      S_REQCHK: begin
        ctrl.row_from_pid = 1'b1;
        if (stat.req_code != ST_LOAD) begin
          code_nxt = stat.req_code;
          state_nxt = S_RESP;
        end else begin
          ctrl.grant = 1'b1;
          state_nxt = S_SCANINIT;
        end
      end
      S_SCANINIT: begin
        ctrl.scan_clear = 1'b1;
        idx_nxt = '0;
        round_nxt = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (stat.fits) begin
          ctrl.scan_take = 1'b1;
          idx_nxt = '0;
          round_nxt = round_r + 1'b1;
          if (round_r == LAST_IDX) begin
            k_nxt = '0;
            state_nxt = S_EMIT;
          end
        end else if (idx_r == LAST_IDX) begin
          code_nxt = ST_UNSAFE;
          state_nxt = is_req_r ? S_ROLLBACK : S_RESP;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_ROLLBACK: begin
        ctrl.rollback = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          ctrl.out_load = 1'b1;
          ctrl.out_status = code_r;
          ctrl.out_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          ctrl.out_load = 1'b1;
          ctrl.out_from_order = 1'b1;
          ctrl.out_status = ST_SAFE;
          ctrl.out_last = (k_r == LAST_IDX);
          k_nxt = k_r + 1'b1;
          if (k_r == LAST_IDX) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r <= '0;
      round_r <= '0;
      k_r <= '0;
      is_req_r <= 1'b0;
      code_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      round_r <= round_nxt;
      k_r <= k_nxt;
      is_req_r <= is_req_nxt;
      code_r <= code_nxt;
    end
  end
endmodule
`default_nettype wire
